// File: rtl/md5_pkg.sv
// md5_pkg: shared types, constants and round tables for the md5 digest block
// depends on nothing; imported by md5_front, md5_back and the top level
package md5_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_IDX  = 6'd63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_msg;
  } cmd_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // indexed by {round group, round low bits}
  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] q;
    logic [3:0] idx;
    q = r[3:0];
    case (r[5:4])
      2'd0:    idx = q;
      2'd1:    idx = 4'(q * 4'd5 + 4'd1);
      2'd2:    idx = 4'(q * 4'd3 + 4'd5);
      default: idx = 4'(q * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

// File: rtl/md5_front.sv
// md5_front: accepts input items, drops empty ones and queues the rest
// depends on md5_pkg (cmd_t, queue depth)
module md5_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          has_byte,
  input  logic          end_of_message,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output md5_pkg::cmd_t cmd
);
  import md5_pkg::*;

  cmd_t             queue [QDEPTH];
  logic [QAW-1:0]   wptr;
  logic [QAW-1:0]   rptr;
  logic [QAW:0]     count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != (QAW+1)'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign push      = in_valid && in_ready && (has_byte || end_of_message);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= '{data_byte: data_byte, has_byte: has_byte, end_msg: end_of_message};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/md5_back.sv
// md5_back: block store, padding sequencer, 64-round compression and digest register
// depends on md5_pkg (cmd_t, tables, initial chaining values)
module md5_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  md5_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   digest_low,
  output logic [63:0]   digest_high
);
  import md5_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]       state;
  logic [5:0]       fill;
  logic [63:0]      bit_length;
  logic [31:0]      ca, cb, cc, cd;
  logic [31:0]      va, vb, vc, vd;
  logic [5:0]       rnd;
  logic             pad_active;
  logic             pad_mark;
  logic             len_mode;

  logic [3:0][7:0]  mem [16];
  logic [31:0]      rd_word;
  logic [3:0]       rd_addr;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic             len_start;
  logic [63:0]      len_shift;

  logic [31:0]      mix;
  logic [31:0]      sum;
  logic [31:0]      nb;

  assign cmd_ready = (state == S_IDLE);
  assign len_start = !pad_mark && !len_mode && (fill == LEN_START);
  assign len_shift = bit_length >> {fill[2:0], 3'b000};

  always_comb begin
    wr_en   = 1'b0;
    wr_data = cmd.data_byte;
    if (state == S_IDLE) begin
      wr_en = cmd_valid && cmd.has_byte;
    end else if (state == S_PAD) begin
      wr_en = 1'b1;
      if (pad_mark) begin
        wr_data = PAD_MARK;
      end else if (len_start || len_mode) begin
        wr_data = len_shift[7:0];
      end else begin
        wr_data = '0;
      end
    end
  end

  assign rd_addr = (state == S_ROUND) ? msg_index(rnd + 6'd1) : '0;

  // byte-lane writes, word reads for the rounds
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill[5:2]][fill[1:0]] <= wr_data;
    end
    rd_word <= mem[rd_addr];
  end

  always_comb begin
    case (rnd[5:4])
      2'd0:    mix = (vb & vc) | (~vb & vd);
      2'd1:    mix = (vd & vb) | (~vd & vc);
      2'd2:    mix = vb ^ vc ^ vd;
      default: mix = vc ^ (vb | ~vd);
    endcase
    sum = mix + va + ROUND_K[rnd] + rd_word;
    nb  = vb + rotl(sum, ROT_AMT[{rnd[5:4], rnd[1:0]}]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      bit_length <= '0;
      ca         <= IV_A;
      cb         <= IV_B;
      cc         <= IV_C;
      cd         <= IV_D;
      pad_active <= 1'b0;
      pad_mark   <= 1'b0;
      len_mode   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.has_byte) begin
              fill       <= fill + 6'd1;
              bit_length <= bit_length + 64'd8;
            end
            if (cmd.end_msg) begin
              pad_active <= 1'b1;
              pad_mark   <= 1'b1;
            end
            if (cmd.has_byte && fill == LAST_IDX) begin
              state <= S_PREP;
            end else if (cmd.end_msg) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill     <= fill + 6'd1;
          pad_mark <= 1'b0;
          if (len_start) len_mode <= 1'b1;
          if (fill == LAST_IDX) state <= S_PREP;
        end
        S_PREP: begin
          va    <= ca;
          vb    <= cb;
          vc    <= cc;
          vd    <= cd;
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          va  <= vd;
          vb  <= nb;
          vc  <= vb;
          vd  <= vc;
          rnd <= rnd + 6'd1;
          if (rnd == LAST_IDX) state <= S_FOLD;
        end
        S_FOLD: begin
          ca <= ca + va;
          cb <= cb + vb;
          cc <= cc + vc;
          cd <= cd + vd;
          if (len_mode) begin
            state <= S_OUT;
          end else if (pad_active) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            digest_low  <= {cb, ca};
            digest_high <= {cd, cc};
            out_valid   <= 1'b1;
            ca          <= IV_A;
            cb          <= IV_B;
            cc          <= IV_C;
            cd          <= IV_D;
            fill        <= '0;
            bit_length  <= '0;
            pad_active  <= 1'b0;
            pad_mark    <= 1'b0;
            len_mode    <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/md5_message_digest_top.sv
// md5_message_digest_top: md5 digest of a byte stream, front queue plus compression back end
// depends on md5_pkg, md5_front and md5_back
//
//   channel  | signals                                   | carries
//   ---------+-------------------------------------------+--------------------------------
//   in       | in_valid, in_ready                        | data_byte, has_byte, end_of_message
//   out      | out_valid, out_ready                      | digest_low, digest_high
//
// the back end takes byte items only while idle; every 64th byte starts a compression (load, 64 rounds, fold)
// an end item adds padding (9 to 72 bytes) and one or two compressions, then loads the
// digest register
// a four-entry item queue lets input continue while the back end compresses
// synchronous reset restores the initial chaining words and clears fill count and length
// the digest register holds its result while out_ready is low; the back end waits on it
module md5_message_digest_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_low,
  output logic [63:0] digest_high
);
  import md5_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  md5_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd)
  );

  md5_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_low  (digest_low),
    .digest_high (digest_high)
  );

endmodule
